### src/cslx_pkg.sv
`timescale 1ns / 1ps

package cslx_pkg;

  // Saturating limit on the length of a word or number.
  localparam int unsigned TOKEN_LEN_MAX = 255;

  // Keyword set, one candidate bit per keyword.
  localparam int unsigned NUM_KW = 9;
  localparam logic [NUM_KW-1:0] ALL_CANDIDATES = '1;

  // Token kind codes as reported on the result channel.
  localparam logic [2:0] KIND_KEYWORD     = 3'd0;
  localparam logic [2:0] KIND_IDENTIFIER  = 3'd1;
  localparam logic [2:0] KIND_NUMBER      = 3'd2;
  localparam logic [2:0] KIND_ARITHMETIC  = 3'd3;
  localparam logic [2:0] KIND_ASSIGNMENT  = 3'd4;
  localparam logic [2:0] KIND_PUNCTUATION = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN     = 3'd6;

  // One source byte, or the end-of-text marker.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } lex_in_t;

  // One reported token.
  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] token_length;
    logic [7:0] token_byte;
    logic       length_overflow;
    logic       last_of_run;
  } lex_out_t;

  // Up to two tokens caused by one input item, first one in res0.
  typedef struct packed {
    logic [1:0] count;
    lex_out_t   res0;
    lex_out_t   res1;
  } lex_pair_t;

  // Keyword text, left aligned, padded with zero bytes.
  function automatic logic [47:0] kw_text(input logic [3:0] k);
    logic [47:0] s;
    begin
      case (k)
        4'd0:    s = {"int", 24'h0};
        4'd1:    s = {"float", 8'h0};
        4'd2:    s = {"char", 16'h0};
        4'd3:    s = "return";
        4'd4:    s = {"if", 32'h0};
        4'd5:    s = {"else", 16'h0};
        4'd6:    s = {"for", 24'h0};
        4'd7:    s = {"while", 8'h0};
        4'd8:    s = {"void", 16'h0};
        default: s = '0;
      endcase
      return s;
    end
  endfunction

  // Keyword length in bytes.
  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] n;
    begin
      case (k)
        4'd0:    n = 3'd3;
        4'd1:    n = 3'd5;
        4'd2:    n = 3'd4;
        4'd3:    n = 3'd6;
        4'd4:    n = 3'd2;
        4'd5:    n = 3'd4;
        4'd6:    n = 3'd3;
        4'd7:    n = 3'd5;
        4'd8:    n = 3'd4;
        default: n = 3'd0;
      endcase
      return n;
    end
  endfunction

  // Character of keyword k at position pos (pos below 6).
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
    logic [47:0] s;
    begin
      s = kw_text(k) << (8 * pos);
      return s[47:40];
    end
  endfunction

endpackage

### src/cslx_scanner.sv
`timescale 1ns / 1ps

module cslx_scanner import cslx_pkg::*; #(
  parameter int unsigned TokenLenMax = TOKEN_LEN_MAX
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  lex_in_t   item_i,
  output lex_pair_t pair_o
);

  localparam int unsigned LenW = $clog2(TokenLenMax + 1);

  typedef enum logic [1:0] {
    ModeIdle,
    ModeWord,
    ModeNumber
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [NUM_KW-1:0] cand_q, cand_d;
  logic [7:0]        last_q, last_d;
  logic              ovf_q, ovf_d;

  logic [7:0]        b;
  logic              is_letter, is_digit, is_space, is_word;
  logic              pending;
  logic [7:0]        rep_len;
  logic              kw_hit;
  lex_out_t          flush_res, single_res;

  // Byte classes.
  assign b         = item_i.byte_in;
  assign is_letter = (b inside {["A":"Z"], ["a":"z"]});
  assign is_digit  = (b inside {["0":"9"]});
  assign is_space  = (b == " ") || (b inside {[8'd9:8'd13]});
  assign is_word   = is_letter || is_digit || (b == "_");
  assign pending   = (mode_q != ModeIdle);

  // Reported length saturates at 255 whatever the counter width.
  if (LenW > 8) begin : g_len_wide
    assign rep_len = (len_q > LenW'(255)) ? 8'hFF : len_q[7:0];
  end else begin : g_len_narrow
    assign rep_len = 8'(len_q);
  end

  // A word is a keyword if a surviving candidate has exactly its length.
  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand_q[k] && (32'(len_q) == 32'(kw_len(4'(k))))) begin
        kw_hit = 1'b1;
      end
    end
  end

  // Result for the pending word or number.
  always_comb begin
    flush_res                 = '0;
    flush_res.token_length    = rep_len;
    flush_res.token_byte      = last_q;
    flush_res.length_overflow = ovf_q;
    if (mode_q == ModeWord) begin
      flush_res.token_kind = (kw_hit && !ovf_q) ? KIND_KEYWORD : KIND_IDENTIFIER;
    end else begin
      flush_res.token_kind = KIND_NUMBER;
    end
  end

  // Result for a one-byte token.
  always_comb begin
    single_res              = '0;
    single_res.token_length = 8'd1;
    single_res.token_byte   = b;
    if (b inside {"+", "-", "*", "/"}) begin
      single_res.token_kind = KIND_ARITHMETIC;
    end else if (b == "=") begin
      single_res.token_kind = KIND_ASSIGNMENT;
    end else if (b inside {";", "(", ")", "{", "}", ","}) begin
      single_res.token_kind = KIND_PUNCTUATION;
    end else begin
      single_res.token_kind = KIND_UNKNOWN;
    end
  end

  // Next state and the results of the current item.
  always_comb begin
    logic              extend, start;
    logic [LenW-1:0]   src_len;
    logic [NUM_KW-1:0] src_cand, match;
    logic              src_ovf;
    logic              pos_ok;

    mode_d = mode_q;
    len_d  = len_q;
    cand_d = cand_q;
    last_d = last_q;
    ovf_d  = ovf_q;
    pair_o = '0;

    extend = !item_i.end_of_text &&
             (((mode_q == ModeWord) && is_word) || ((mode_q == ModeNumber) && is_digit));
    start  = !item_i.end_of_text && !extend && (is_letter || is_digit || (b == "_"));

    // Take the byte into the token, from a fresh start or from the pending one.
    src_len  = start ? '0 : len_q;
    src_cand = start ? ALL_CANDIDATES : cand_q;
    src_ovf  = start ? 1'b0 : ovf_q;
    pos_ok   = (32'(src_len) < 32'd8);
    match    = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (pos_ok && (32'(src_len) < 32'(kw_len(4'(k)))) &&
          (kw_char(4'(k), src_len[2:0]) == b)) begin
        match[k] = 1'b1;
      end
    end

    if (item_i.end_of_text) begin
      // Flush any pending token and return to the reset state.
      if (pending) begin
        pair_o.count = 2'd1;
        pair_o.res0  = flush_res;
      end
      mode_d = ModeIdle;
      len_d  = '0;
      cand_d = ALL_CANDIDATES;
      last_d = '0;
      ovf_d  = 1'b0;
    end else if (extend || start) begin
      if (start) begin
        if (pending) begin
          pair_o.count = 2'd1;
          pair_o.res0  = flush_res;
        end
        mode_d = is_digit ? ModeNumber : ModeWord;
      end
      if (32'(src_len) < 32'(TokenLenMax)) begin
        cand_d = src_cand & match;
        len_d  = src_len + LenW'(1);
        ovf_d  = src_ovf;
      end else begin
        cand_d = '0;
        len_d  = src_len;
        ovf_d  = 1'b1;
      end
      last_d = b;
    end else begin
      // Separator or one-byte token ends any pending token.
      mode_d = ModeIdle;
      if (!is_space) begin
        if (pending) begin
          pair_o.count = 2'd2;
          pair_o.res0  = flush_res;
          pair_o.res1  = single_res;
        end else begin
          pair_o.count = 2'd1;
          pair_o.res0  = single_res;
        end
      end else if (pending) begin
        pair_o.count = 2'd1;
        pair_o.res0  = flush_res;
      end
    end

    // The final result of the item carries the run marker.
    pair_o.res0.last_of_run = (pair_o.count == 2'd1);
    pair_o.res1.last_of_run = (pair_o.count == 2'd2);
  end

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      len_q  <= '0;
      cand_q <= ALL_CANDIDATES;
      last_q <= '0;
      ovf_q  <= 1'b0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      cand_q <= cand_d;
      last_q <= last_d;
      ovf_q  <= ovf_d;
    end
  end

`ifndef SYNTH
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeIdle || mode_q == ModeWord || mode_q == ModeNumber)
    else $error("scanner mode holds an illegal encoding");

  a_ovf_no_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != ModeIdle) && ovf_q |-> (cand_q == '0))
    else $error("overlong token still has keyword candidates");

  a_pair_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (pair_o.count == 2'd2) |-> (mode_q != ModeIdle))
    else $error("two results without a pending token");
`endif

endmodule

### src/cslx_out_buf.sv
`timescale 1ns / 1ps

module cslx_out_buf import cslx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  lex_pair_t pair_i,
  output logic      can_load_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lex_out_t  out_data_o
);

  logic [1:0] cnt_q;
  lex_out_t   slot0_q, slot1_q;
  logic       take;

  // A result leaves on every transfer; a new pair may enter once at most one remains
  // and that one leaves in this cycle.
  assign take        = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= pair_i.count;
    end else if (take) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Result slots.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= pair_i.res0;
      slot1_q <= pair_i.res1;
    end else if (take) begin
      slot0_q <= slot1_q;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !slot0_q.last_of_run)
    else $error("first of two results marked as last");

  a_pair_drains_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |=> (cnt_q != 2'd0))
    else $error("two results left the buffer in one cycle");
`endif

endmodule

### src/c_subset_lexer_core.sv
`timescale 1ns / 1ps
// Path: an item waits in the input register, is scanned there and its results are loaded
// into the result buffer; a full result buffer holds the item in the input register.
// Throughput: one item per cycle while each item gives at most one result and the output
// is not stalled; an item that gives two results holds the input while both wait in the buffer.
// Reset: asynchronous, active low; clears the scanner to idle with no token pending,
// and empties the input and result registers.

module c_subset_lexer_core import cslx_pkg::*; #(
  parameter int unsigned TokenLenMax = TOKEN_LEN_MAX
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lex_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lex_out_t out_data_o
);

  logic      in_valid_q;
  lex_in_t   in_data_q;
  logic      can_load;
  logic      advance;
  lex_pair_t pair;

  // Input register moves on whenever the result buffer can take its results.
  assign advance    = in_valid_q && can_load;
  assign in_stall_o = in_valid_q && !can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Token scanner.
  cslx_scanner #(
    .TokenLenMax(TokenLenMax)
  ) u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .item_i   (in_data_q),
    .pair_o   (pair)
  );

  // Result buffer.
  cslx_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .pair_i     (pair),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

### tb/tb_c_subset_lexer_core.sv
`timescale 1ns / 1ps

module tb_c_subset_lexer_core;
  import cslx_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 210;
  localparam int unsigned QUIET_LIMIT  = 2000;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} scan_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  lex_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  lex_out_t out_data_o;

  // Source bytes waiting to be sent, and tokens still owed by the block.
  lex_in_t  source_bytes [$];
  lex_out_t tokens_due [$];

  int unsigned n_total     = 0;
  int unsigned n_taken     = 0;
  int unsigned failures    = 0;
  int unsigned quiet_count = 0;
  bit          in_sent     = 1'b0;
  logic        calm_run;

  // Scanner state as the predictor sees it.
  scan_e       mode     = SCAN_IDLE;
  int unsigned run_len  = 0;
  logic [8:0]  kw_live  = '1;
  logic [7:0]  run_last = '0;
  bit          run_ovf  = 1'b0;

  string kw_word [9] = '{"int", "float", "char", "return", "if", "else", "for", "while",
                         "void"};

  c_subset_lexer_core uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Both sides run without idling for a stretch in the middle of the run.
  assign calm_run = (n_taken >= 300) && (n_taken < 450);

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit is_num(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic lex_out_t token(input logic [2:0] kind, input logic [7:0] len,
                                     input logic [7:0] b, input logic ovf);
    lex_out_t t;
    t.token_kind      = kind;
    t.token_length    = len;
    t.token_byte      = b;
    t.length_overflow = ovf;
    t.last_of_run     = 1'b0;
    return t;
  endfunction

  // Extend the pending word or number, narrowing the keyword candidates by position.
  function automatic void add_to_run(input logic [7:0] b);
    logic [8:0] still;
    if (run_len < TOKEN_LEN_MAX) begin
      still = '0;
      for (int k = 0; k < 9; k++) begin
        if (kw_live[k] && run_len < kw_word[k].len() && kw_word[k][run_len] == b) begin
          still[k] = 1'b1;
        end
      end
      kw_live = still;
      run_len++;
    end else begin
      run_ovf = 1'b1;
      kw_live = '0;
    end
    run_last = b;
  endfunction

  function automatic void open_run(input scan_e m, input logic [7:0] b);
    mode    = m;
    run_len = 0;
    run_ovf = 1'b0;
    kw_live = '1;
    add_to_run(b);
  endfunction

  // Report the pending token and return to idle.
  function automatic lex_out_t close_run();
    logic [2:0] kind;
    kind = KIND_NUMBER;
    if (mode == SCAN_WORD) begin
      kind = KIND_IDENTIFIER;
      if (!run_ovf) begin
        for (int k = 0; k < 9; k++) begin
          if (kw_live[k] && kw_word[k].len() == run_len) begin
            kind = KIND_KEYWORD;
          end
        end
      end
    end
    mode = SCAN_IDLE;
    return token(kind, (run_len > 255) ? 8'd255 : 8'(run_len), run_last, run_ovf);
  endfunction

  // Work out the tokens that one accepted source byte causes.
  function automatic void predict_tokens(input lex_in_t item);
    lex_out_t   made [$];
    logic [7:0] b;
    logic [2:0] kind;
    bit         word_byte;
    b = item.byte_in;
    word_byte = is_alpha(b) || is_num(b) || b == "_";
    if (item.end_of_text) begin
      if (mode != SCAN_IDLE) made.push_back(close_run());
      mode     = SCAN_IDLE;
      run_len  = 0;
      kw_live  = '1;
      run_last = '0;
      run_ovf  = 1'b0;
    end else if (mode == SCAN_WORD && word_byte) begin
      add_to_run(b);
    end else if (mode == SCAN_NUMBER && is_num(b)) begin
      add_to_run(b);
    end else begin
      if (mode != SCAN_IDLE) made.push_back(close_run());
      if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
        // A separator gives nothing of its own.
      end else if (is_alpha(b) || b == "_") begin
        open_run(SCAN_WORD, b);
      end else if (is_num(b)) begin
        open_run(SCAN_NUMBER, b);
      end else begin
        case (b)
          "+", "-", "*", "/":           kind = KIND_ARITHMETIC;
          "=":                          kind = KIND_ASSIGNMENT;
          ";", "(", ")", "{", "}", ",": kind = KIND_PUNCTUATION;
          default:                      kind = KIND_UNKNOWN;
        endcase
        made.push_back(token(kind, 8'd1, b, 1'b0));
      end
    end
    if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
    foreach (made[i]) tokens_due.push_back(made[i]);
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    lex_in_t it;
    it.byte_in     = b;
    it.end_of_text = 1'b0;
    source_bytes.push_back(it);
  endfunction

  function automatic void push_eot();
    lex_in_t it;
    it.byte_in     = 8'($urandom_range(0, 255));
    it.end_of_text = 1'b1;
    source_bytes.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // A letter, an underscore or, past the first position, a digit.
  function automatic logic [7:0] word_char(input bit lead);
    int unsigned r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      failures++;
    end
  endtask

  // Fill the source queue: a directed opening, two long tokens, then random text.
  initial begin
    string       w;
    string       symbols;
    int unsigned sel;
    int unsigned n;
    int unsigned base;
    symbols = "+-*/=;(){},";

    push_text("while(_9=");
    push_text("+-*/;");
    push_text("{},7b");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'd9);
    push_byte(8'd11);
    push_eot();
    push_text("5");
    push_eot();

    push_byte(word_char(1'b1));
    n = $urandom_range(255, 258);
    repeat (n) push_byte(word_char(1'b0));
    push_byte(";");
    n = $urandom_range(255, 258);
    repeat (n) push_byte(8'("0" + $urandom_range(0, 9)));
    push_eot();

    base = source_bytes.size();
    while (source_bytes.size() < base + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        // Keywords, whole or altered so that the candidate mask drops out late.
        w = kw_word[$urandom_range(0, 8)];
        case ($urandom_range(0, 4))
          0: w = w.substr(0, $urandom_range(0, w.len() - 2));
          1: w = {w, string'(word_char(1'b0))};
          2: w[$urandom_range(0, w.len() - 1)] = word_char(1'b0);
          3: w = w.toupper();
          default: ;
        endcase
        push_text(w);
      end else if (sel < 35) begin
        push_byte(word_char(1'b1));
        repeat ($urandom_range(0, 11)) push_byte(word_char(1'b0));
      end else if (sel < 48) begin
        repeat ($urandom_range(1, 8)) push_byte(8'("0" + $urandom_range(0, 9)));
      end else if (sel < 68) begin
        push_byte(symbols[$urandom_range(0, symbols.len() - 1)]);
      end else if (sel < 80) begin
        n = $urandom_range(8, 13);
        push_byte((n == 8) ? 8'd32 : 8'(n));
      end else if (sel < 93) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_eot();
      end
    end
    n_total = source_bytes.size();
  end

  // Input driver: a new transfer is offered only once the last one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_sent) begin
        in_sent = 1'b0;
        if (source_bytes.size() > 0 && (calm_run || $urandom_range(0, 99) >= 29)) begin
          in_data_i  <= source_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm_run && ($urandom_range(0, 99) < 29);
    end
  end

  // Predict at each input transfer, and check each result transfer in order.
  always @(posedge clk_i) begin
    lex_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_tokens(in_data_i);
        in_sent = 1'b1;
        n_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: token with no expectation, expected none, actual kind %0d byte %0d",
                   $time, out_data_o.token_kind, out_data_o.token_byte);
          failures++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", want.token_kind, out_data_o.token_kind);
          check_field("token_length", want.token_length, out_data_o.token_length);
          check_field("token_byte", want.token_byte, out_data_o.token_byte);
          check_field("length_overflow", want.length_overflow, out_data_o.length_overflow);
          check_field("last_of_run", want.last_of_run, out_data_o.last_of_run);
        end
      end
      // Watchdog on cycles without any transfer.
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
      end
      if (quiet_count == QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Reset once, then wait for every byte to be taken and every token to arrive.
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (n_taken < n_total || tokens_due.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
src/cslx_pkg.sv
src/cslx_scanner.sv
src/cslx_out_buf.sv
src/c_subset_lexer_core.sv
tb/tb_c_subset_lexer_core.sv
